// ===== src/dpcg_pkg.sv =====
// Shared types and constants for the disk placement cell grid.
// Holds the transaction structs, the slot entry layout and command codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpcg_pkg;

    // Fixed field widths
    localparam int POS_W  = 22;
    localparam int ID_W   = 14;
    localparam int CNT_W  = 15;
    localparam int CFG_W  = 7;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_GRID_SIDE  = 64;
    localparam int DEF_SLOTS_PER_CELL = 4;
    localparam int DEF_FRAC_BITS      = 16;

    localparam int              MIN_SIDE   = 3;
    localparam logic [CFG_W-1:0] SIDE_RESET = 7'd64;
    localparam logic [CNT_W-1:0] COUNT_MAX  = 15'h7FFF;

    // Register indexes (paddr[2])
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_PLACE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [ID_W-1:0]  slot_index;
    } item_t;

    typedef struct packed {
        logic             accepted;
        logic             slot_occupied;
        logic [POS_W-1:0] slot_x;
        logic [POS_W-1:0] slot_y;
        logic [ID_W-1:0]  slot_id;
        logic [CNT_W-1:0] placed_count;
    } result_t;

    // One slot of the store
    typedef struct packed {
        logic             occ;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [ID_W-1:0]  id;
    } slot_t;

endpackage

`default_nettype wire

// ===== src/dpcg_dist.sv =====
// Three-stage overlap check of one stored disk against the candidate.
// Depends on dpcg_pkg for the coordinate width.
`timescale 1ns / 1ps
`default_nettype none

module dpcg_dist #(
    parameter int FRAC_BITS = dpcg_pkg::DEF_FRAC_BITS,
    parameter int DW        = 25
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          chk_valid,
    input  wire logic [dpcg_pkg::POS_W-1:0]    st_x,
    input  wire logic [dpcg_pkg::POS_W-1:0]    st_y,
    input  wire logic signed [DW-1:0]          off_x,
    input  wire logic signed [DW-1:0]          off_y,
    input  wire logic [dpcg_pkg::POS_W-1:0]    pos_x,
    input  wire logic [dpcg_pkg::POS_W-1:0]    pos_y,
    output logic                               near_valid,
    output logic                               near,
    output logic                               busy
);
    import dpcg_pkg::*;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        ax;
    logic [DW-1:0]        ay;
    logic                 close_a;

    logic                   a_valid_reg;
    logic                   a_close_reg;
    logic [FRAC_BITS-1:0]   a_mx_reg;
    logic [FRAC_BITS-1:0]   a_my_reg;
    logic                   b_valid_reg;
    logic                   b_close_reg;
    logic [2*FRAC_BITS-1:0] b_sqx_reg;
    logic [2*FRAC_BITS-1:0] b_sqy_reg;
    logic [2*FRAC_BITS:0]   sum;
    logic                   near_valid_reg;
    logic                   near_reg;
    logic                   near_next;

    // shifted stored position minus candidate, then magnitude
    assign dx = $signed({{(DW-POS_W){1'b0}}, st_x}) + off_x
              - $signed({{(DW-POS_W){1'b0}}, pos_x});
    assign dy = $signed({{(DW-POS_W){1'b0}}, st_y}) + off_y
              - $signed({{(DW-POS_W){1'b0}}, pos_y});
    assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign close_a = (ax[DW-1:FRAC_BITS] == '0) && (ay[DW-1:FRAC_BITS] == '0);

    assign sum       = {1'b0, b_sqx_reg} + {1'b0, b_sqy_reg};
    assign near_next = b_close_reg && !sum[2*FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            near_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg    <= chk_valid;
            b_valid_reg    <= a_valid_reg;
            near_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_close_reg <= close_a;
        a_mx_reg    <= ax[FRAC_BITS-1:0];
        a_my_reg    <= ay[FRAC_BITS-1:0];
        b_close_reg <= a_close_reg;
        b_sqx_reg   <= a_mx_reg * a_mx_reg;
        b_sqy_reg   <= a_my_reg * a_my_reg;
        near_reg    <= near_next;
    end

    assign near_valid = near_valid_reg;
    assign near       = near_reg;
    assign busy       = a_valid_reg || b_valid_reg || near_valid_reg;

endmodule

`default_nettype wire

// ===== src/disk_placement_cell_grid.sv =====
// Top level of the disk placement cell grid: slot memory, sequencer, APB registers.
// Depends on dpcg_pkg and dpcg_dist.
`timescale 1ns / 1ps
`default_nettype none

// Places unit-diameter disks on a periodic grid of cells, SLOTS_PER_CELL slots per
// cell, all slots held in one single-port-read, single-port-write memory. One command
// is handled at a time. A place command sweeps the 3x3 neighbor cells one slot per cycle
// through the memory read port: each cell takes an address setup step and then
// SLOTS_PER_CELL reads; then the overlap pipeline drains and, if no stored disk overlaps
// and the own cell has a free slot, that slot is written. A candidate outside the box
// skips the sweep and goes straight to its result. A clear walks the whole memory one
// slot per cycle, MAX_GRID_SIDE^2*SLOTS_PER_CELL slots (16384 by default); the same pass
// runs after reset, and item_stall stays high until it ends. A stalled result holds the
// next command back. grid_width and grid_height may only be written while no command
// is in flight.
module disk_placement_cell_grid #(
    parameter int MAX_GRID_SIDE  = dpcg_pkg::DEF_MAX_GRID_SIDE,
    parameter int SLOTS_PER_CELL = dpcg_pkg::DEF_SLOTS_PER_CELL,
    parameter int FRAC_BITS      = dpcg_pkg::DEF_FRAC_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire dpcg_pkg::item_t                item,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output dpcg_pkg::result_t                   result,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dpcg_pkg::APB_AW-1:0]    paddr,
    input  wire logic [dpcg_pkg::APB_DW-1:0]    pwdata,
    output logic [dpcg_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import dpcg_pkg::*;

    localparam int SW    = $clog2(MAX_GRID_SIDE + 1);
    localparam int DEPTH = MAX_GRID_SIDE * MAX_GRID_SIDE * SLOTS_PER_CELL;
    localparam int AW    = $clog2(DEPTH);
    localparam int SLW   = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
    localparam int DW    = ((POS_W > SW + FRAC_BITS) ? POS_W : SW + FRAC_BITS) + 2;
    localparam int IXW   = ((AW > ID_W) ? AW : ID_W) + 1;

    localparam logic [1:0] NBR_LO  = 2'd0;
    localparam logic [1:0] NBR_MID = 2'd1;
    localparam logic [1:0] NBR_HI  = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CLEAR  = 7'b0000010,
        ST_SETUP  = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_DRAIN  = 7'b0010000,
        ST_RDSLOT = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    // configuration
    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [SW-1:0]    w_sat;
    logic [SW-1:0]    h_sat;
    logic             cfg_write;

    // sequencer
    state_t            state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    logic [POS_W-1:0]  px_reg, px_next;
    logic [POS_W-1:0]  py_reg, py_next;
    logic [SW-1:0]     cx_reg, cx_next;
    logic [SW-1:0]     cy_reg, cy_next;
    logic [1:0]        col_reg, col_next;
    logic [1:0]        row_reg, row_next;
    logic [SLW-1:0]    slot_reg, slot_next;
    logic [AW-1:0]     cell_base_reg, cell_base_next;
    logic [AW-1:0]     own_base_reg, own_base_next;
    logic signed [DW-1:0] offx_reg, offx_next;
    logic signed [DW-1:0] offy_reg, offy_next;
    logic              own_cell_reg, own_cell_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic              clr_report_reg, clr_report_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              hit_reg, hit_next;
    logic              free_found_reg, free_found_next;
    logic [SLW-1:0]    free_slot_reg, free_slot_next;
    logic              place_ok_reg, place_ok_next;
    logic              rd_in_range_reg, rd_in_range_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;

    // read pipeline tags, aligned with rdata_reg
    logic                 tag_valid_reg, tag_valid_next;
    logic signed [DW-1:0] tag_offx_reg;
    logic signed [DW-1:0] tag_offy_reg;
    logic                 tag_own_reg;
    logic [SLW-1:0]       tag_slot_reg;

    // output register
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;
    result_t result_build;
    logic    result_load;
    logic    read_hit;

    // memory
    slot_t         slot_mem [DEPTH];
    slot_t         rdata_reg;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    slot_t         mem_wr_data;

    // helpers
    logic             accept;
    logic [POS_W-1:0] cx_full;
    logic [POS_W-1:0] cy_full;
    logic [IXW-1:0]   idx_ext;
    logic [SW-1:0]    nx;
    logic [SW-1:0]    ny;
    logic [DW-1:0]    wrap_x;
    logic [DW-1:0]    wrap_y;
    logic             last_slot;

    // overlap checker
    logic chk_valid;
    logic near_valid;
    logic near;
    logic chk_busy;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_GRID_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                REG_GRID_HEIGHT: height_next = pwdata[CFG_W-1:0];
                default:         width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_GRID_WIDTH:  prdata = APB_DW'(width_reg);
            REG_GRID_HEIGHT: prdata = APB_DW'(height_reg);
            default:         prdata = '0;
        endcase
    end

    // saturate box size to the supported range
    assign w_sat = (int'(width_reg) < MIN_SIDE) ? SW'(MIN_SIDE) :
                   (int'(width_reg) > MAX_GRID_SIDE) ? SW'(MAX_GRID_SIDE) : SW'(width_reg);
    assign h_sat = (int'(height_reg) < MIN_SIDE) ? SW'(MIN_SIDE) :
                   (int'(height_reg) > MAX_GRID_SIDE) ? SW'(MAX_GRID_SIDE) : SW'(height_reg);

    assign wrap_x = DW'(w_sat) << FRAC_BITS;
    assign wrap_y = DW'(h_sat) << FRAC_BITS;

    // ---------------- sequencer ----------------
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign cx_full    = item.pos_x >> FRAC_BITS;
    assign cy_full    = item.pos_y >> FRAC_BITS;
    assign idx_ext    = IXW'(item.slot_index);
    assign last_slot  = (slot_reg == SLW'(SLOTS_PER_CELL - 1));

    assign tag_valid_next = (state_reg == ST_SCAN);
    assign chk_valid      = tag_valid_reg && rdata_reg.occ;

    assign read_hit = (cmd_reg == CMD_READ) && rd_in_range_reg && rdata_reg.occ;

    always_comb
    begin
        result_build.accepted      = (cmd_reg == CMD_PLACE) && place_ok_reg;
        result_build.slot_occupied = read_hit;
        result_build.slot_x        = read_hit ? rdata_reg.x  : '0;
        result_build.slot_y        = read_hit ? rdata_reg.y  : '0;
        result_build.slot_id       = read_hit ? rdata_reg.id : '0;
        result_build.placed_count  = count_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        slot_next        = slot_reg;
        cell_base_next   = cell_base_reg;
        own_base_next    = own_base_reg;
        offx_next        = offx_reg;
        offy_next        = offy_reg;
        own_cell_next    = own_cell_reg;
        clr_addr_next    = clr_addr_reg;
        clr_report_next  = clr_report_reg;
        count_next       = count_reg;
        hit_next         = hit_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        place_ok_next    = place_ok_reg;
        rd_in_range_next = rd_in_range_reg;
        rd_addr_next     = rd_addr_reg;
        result_load      = 1'b0;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = rd_addr_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = clr_addr_reg;
        mem_wr_data      = '0;
        nx               = cx_reg;
        ny               = cy_reg;

        // gather overlap hits and the first free slot of the own cell
        if (near_valid && near)
        begin
            hit_next = 1'b1;
        end
        if (tag_valid_reg && tag_own_reg && !rdata_reg.occ && !free_found_reg)
        begin
            free_found_next = 1'b1;
            free_slot_next  = tag_slot_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = item.cmd;
                    px_next  = item.pos_x;
                    py_next  = item.pos_y;
                    case (item.cmd)
                        CMD_CLEAR:
                        begin
                            clr_addr_next   = '0;
                            clr_report_next = 1'b1;
                            count_next      = '0;
                            state_next      = ST_CLEAR;
                        end
                        CMD_PLACE:
                        begin
                            hit_next        = 1'b0;
                            free_found_next = 1'b0;
                            col_next        = NBR_LO;
                            row_next        = NBR_LO;
                            cx_next         = cx_full[SW-1:0];
                            cy_next         = cy_full[SW-1:0];
                            place_ok_next   = 1'b0;
                            if ((cx_full >= POS_W'(w_sat)) || (cy_full >= POS_W'(h_sat)))
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SETUP;
                            end
                        end
                        CMD_READ:
                        begin
                            rd_addr_next     = idx_ext[AW-1:0];
                            rd_in_range_next = (idx_ext < IXW'(DEPTH));
                            state_next       = (idx_ext < IXW'(DEPTH)) ? ST_RDSLOT : ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_addr_reg;
                mem_wr_data = '0;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = clr_report_reg ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            ST_SETUP:
            begin
                // wrap the neighbor cell and pick the matching coordinate shift
                offx_next = '0;
                offy_next = '0;
                case (col_reg)
                    NBR_LO:
                    begin
                        if (cx_reg == '0)
                        begin
                            nx        = w_sat - 1'b1;
                            offx_next = -$signed(wrap_x);
                        end
                        else
                        begin
                            nx = cx_reg - 1'b1;
                        end
                    end
                    NBR_HI:
                    begin
                        if (cx_reg == w_sat - 1'b1)
                        begin
                            nx        = '0;
                            offx_next = $signed(wrap_x);
                        end
                        else
                        begin
                            nx = cx_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        nx = cx_reg;
                    end
                endcase
                case (row_reg)
                    NBR_LO:
                    begin
                        if (cy_reg == '0)
                        begin
                            ny        = h_sat - 1'b1;
                            offy_next = -$signed(wrap_y);
                        end
                        else
                        begin
                            ny = cy_reg - 1'b1;
                        end
                    end
                    NBR_HI:
                    begin
                        if (cy_reg == h_sat - 1'b1)
                        begin
                            ny        = '0;
                            offy_next = $signed(wrap_y);
                        end
                        else
                        begin
                            ny = cy_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        ny = cy_reg;
                    end
                endcase
                cell_base_next = AW'((ny * w_sat + nx) * SLOTS_PER_CELL);
                own_cell_next  = (col_reg == NBR_MID) && (row_reg == NBR_MID);
                if ((col_reg == NBR_MID) && (row_reg == NBR_MID))
                begin
                    own_base_next = AW'((ny * w_sat + nx) * SLOTS_PER_CELL);
                end
                slot_next  = '0;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = cell_base_reg + AW'(slot_reg);
                if (last_slot)
                begin
                    if ((col_reg == NBR_HI) && (row_reg == NBR_HI))
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        if (row_reg == NBR_HI)
                        begin
                            row_next = NBR_LO;
                            col_next = col_reg + 1'b1;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                        state_next = ST_SETUP;
                    end
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                // hold until every read slot has been checked
                if (!tag_valid_reg && !chk_busy)
                begin
                    if (!hit_reg && free_found_reg)
                    begin
                        mem_wr_en       = 1'b1;
                        mem_wr_addr     = own_base_reg + AW'(free_slot_reg);
                        mem_wr_data.occ = 1'b1;
                        mem_wr_data.x   = px_reg;
                        mem_wr_data.y   = py_reg;
                        mem_wr_data.id  = count_reg[ID_W-1:0];
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        place_ok_next = 1'b1;
                    end
                    else
                    begin
                        place_ok_next = 1'b0;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_RDSLOT:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = rd_addr_reg;
                state_next  = ST_DONE;
            end

            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_load     = 1'b1;
                    clr_report_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register: free once the current transaction is taken
    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        if (result_load)
        begin
            result_valid_next = 1'b1;
            result_next       = result_build;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= SIDE_RESET;
            height_reg       <= SIDE_RESET;
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            clr_report_reg   <= 1'b0;
            count_reg        <= '0;
            hit_reg          <= 1'b0;
            free_found_reg   <= 1'b0;
            col_reg          <= NBR_LO;
            row_reg          <= NBR_LO;
            tag_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg        <= width_next;
            height_reg       <= height_next;
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            clr_report_reg   <= clr_report_next;
            count_reg        <= count_next;
            hit_reg          <= hit_next;
            free_found_reg   <= free_found_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            tag_valid_reg    <= tag_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        px_reg          <= px_next;
        py_reg          <= py_next;
        cx_reg          <= cx_next;
        cy_reg          <= cy_next;
        slot_reg        <= slot_next;
        cell_base_reg   <= cell_base_next;
        own_base_reg    <= own_base_next;
        offx_reg        <= offx_next;
        offy_reg        <= offy_next;
        own_cell_reg    <= own_cell_next;
        free_slot_reg   <= free_slot_next;
        place_ok_reg    <= place_ok_next;
        rd_in_range_reg <= rd_in_range_next;
        rd_addr_reg     <= rd_addr_next;
        tag_offx_reg    <= offx_reg;
        tag_offy_reg    <= offy_reg;
        tag_own_reg     <= own_cell_reg;
        tag_slot_reg    <= slot_reg;
        result_reg      <= result_next;
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            slot_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rdata_reg <= slot_mem[mem_rd_addr];
        end
    end

    dpcg_dist #(
        .FRAC_BITS (FRAC_BITS),
        .DW        (DW)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .chk_valid  (chk_valid),
        .st_x       (rdata_reg.x),
        .st_y       (rdata_reg.y),
        .off_x      (tag_offx_reg),
        .off_y      (tag_offy_reg),
        .pos_x      (px_reg),
        .pos_y      (py_reg),
        .near_valid (near_valid),
        .near       (near),
        .busy       (chk_busy)
    );

    // ---------------- assertions ----------------
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && mem_wr_en) |=>
            (count_reg == $past(count_reg) + 1'b1) || (count_reg == COUNT_MAX))
        else $error("placement did not advance the disk count");

    a_count_source: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |->
            ($past(state_reg) == ST_DRAIN) || ($past(state_reg) == ST_IDLE))
        else $error("disk count changed outside placement or clear");

    a_tag_window: assert property (@(posedge clk) disable iff (!rst_n)
        tag_valid_reg |->
            (state_reg == ST_SETUP) || (state_reg == ST_SCAN) || (state_reg == ST_DRAIN))
        else $error("slot read data arrived outside a neighbor sweep");

endmodule

`default_nettype wire

// ===== test/disk_placement_cell_grid_tb.sv =====
// Self-checking testbench for disk_placement_cell_grid: random and directed
// clear/place/read traffic with an occupancy model of the slot store.
// Depends on dpcg_pkg and the disk_placement_cell_grid RTL.
`timescale 1ns / 1ps

module disk_placement_cell_grid_tb;
    import dpcg_pkg::*;

    localparam int     FRAC       = DEF_FRAC_BITS;
    localparam int     SLOTS      = DEF_SLOTS_PER_CELL;
    localparam int     MAX_SIDE   = DEF_MAX_GRID_SIDE;
    localparam int     SLOT_COUNT = MAX_SIDE * MAX_SIDE * SLOTS;
    localparam longint ONE_FIX    = 64'sd1 << FRAC;
    localparam int     PHASES          = 6;
    localparam int     ITEMS_PER_PHASE = 116;
    localparam int     LONG_HOLD       = 400;
    localparam int     DRAIN_CYCLES    = 80;
    localparam int     WATCHDOG_CYCLES = 120000;

    // Occupancy of every slot plus the placement count; predicts one outcome per command.
    class grid_occupancy;
        logic [CFG_W-1:0] width_reg  = SIDE_RESET;
        logic [CFG_W-1:0] height_reg = SIDE_RESET;
        bit        occ    [SLOT_COUNT];
        int        slot_x [SLOT_COUNT];
        int        slot_y [SLOT_COUNT];
        int        slot_id[SLOT_COUNT];
        int        disk_count;
        int        placed_at[$];
        result_t   outcomes_due[$];

        function void set_reg(logic idx, logic [CFG_W-1:0] value);
            if (idx == REG_GRID_WIDTH)
                width_reg = value;
            else
                height_reg = value;
        endfunction

        function int side(logic [CFG_W-1:0] r);
            if (r < MIN_SIDE)
                return MIN_SIDE;
            if (r > MAX_SIDE)
                return MAX_SIDE;
            return int'(r);
        endfunction

        function void wipe();
            int i;
            for (i = 0; i < SLOT_COUNT; i++)
                occ[i] = 1'b0;
            disk_count = 0;
            placed_at.delete();
        endfunction

        function bit overlaps(longint ax, longint ay, longint bx, longint by);
            longint dx;
            longint dy;
            dx = ax - bx;
            dy = ay - by;
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            if (dx >= ONE_FIX || dy >= ONE_FIX)
                return 1'b0;
            return (dx * dx + dy * dy) < (ONE_FIX * ONE_FIX);
        endfunction

        function bit try_place(longint px, longint py);
            longint w, h, cx, cy, nx, ny, ox, oy, base, a;
            int ddx, ddy, s;
            w  = side(width_reg);
            h  = side(height_reg);
            cx = px >> FRAC;
            cy = py >> FRAC;
            if (cx >= w || cy >= h)
                return 1'b0;
            for (ddx = -1; ddx <= 1; ddx++)
                for (ddy = -1; ddy <= 1; ddy++)
                begin
                    nx = cx + ddx;
                    ny = cy + ddy;
                    ox = 0;
                    oy = 0;
                    // wrap the neighbor cell and shift its disks by the box size
                    if (nx < 0)
                    begin
                        nx = nx + w;
                        ox = -(w << FRAC);
                    end
                    else if (nx >= w)
                    begin
                        nx = nx - w;
                        ox = w << FRAC;
                    end
                    if (ny < 0)
                    begin
                        ny = ny + h;
                        oy = -(h << FRAC);
                    end
                    else if (ny >= h)
                    begin
                        ny = ny - h;
                        oy = h << FRAC;
                    end
                    base = (ny * w + nx) * SLOTS;
                    for (s = 0; s < SLOTS; s++)
                    begin
                        a = base + s;
                        if (occ[a] && overlaps(slot_x[a] + ox, slot_y[a] + oy, px, py))
                            return 1'b0;
                    end
                end
            base = (cy * w + cx) * SLOTS;
            for (s = 0; s < SLOTS; s++)
            begin
                a = base + s;
                if (!occ[a])
                begin
                    occ[a]     = 1'b1;
                    slot_x[a]  = int'(px);
                    slot_y[a]  = int'(py);
                    slot_id[a] = disk_count % (1 << ID_W);
                    if (disk_count < COUNT_MAX)
                        disk_count++;
                    placed_at = {placed_at, int'(a)};
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void take_command(item_t it);
            result_t r;
            int a;
            r = '0;
            case (cmd_t'(it.cmd))
                CMD_CLEAR: wipe();
                CMD_PLACE: r.accepted = try_place(longint'(it.pos_x), longint'(it.pos_y));
                CMD_READ:
                begin
                    a = int'(it.slot_index);
                    if (occ[a])
                    begin
                        r.slot_occupied = 1'b1;
                        r.slot_x  = slot_x[a][POS_W-1:0];
                        r.slot_y  = slot_y[a][POS_W-1:0];
                        r.slot_id = slot_id[a][ID_W-1:0];
                    end
                end
                default: ;
            endcase
            r.placed_count = disk_count[CNT_W-1:0];
            outcomes_due = {outcomes_due, r};
        endfunction

        // Returns an empty string when the outcome matches the oldest one due.
        function string match_outcome(result_t got);
            result_t want;
            string   msg;
            msg = "";
            if (outcomes_due.size() == 0)
                return " result with no command outstanding";
            want = outcomes_due.pop_front();
            if (got.accepted !== want.accepted)
                msg = {msg, $sformatf(" accepted %0b/%0b", got.accepted, want.accepted)};
            if (got.slot_occupied !== want.slot_occupied)
                msg = {msg, $sformatf(" slot_occupied %0b/%0b",
                                      got.slot_occupied, want.slot_occupied)};
            if (got.slot_x !== want.slot_x)
                msg = {msg, $sformatf(" slot_x %h/%h", got.slot_x, want.slot_x)};
            if (got.slot_y !== want.slot_y)
                msg = {msg, $sformatf(" slot_y %h/%h", got.slot_y, want.slot_y)};
            if (got.slot_id !== want.slot_id)
                msg = {msg, $sformatf(" slot_id %0d/%0d", got.slot_id, want.slot_id)};
            if (got.placed_count !== want.placed_count)
                msg = {msg, $sformatf(" placed_count %0d/%0d",
                                      got.placed_count, want.placed_count)};
            return msg;
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    item_t               item;
    logic                result_valid;
    logic                result_stall;
    result_t             result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    grid_occupancy board;
    bit  hold_req  = 1'b0;
    bit  no_idling = 1'b0;
    int  errors    = 0;
    int  commands_seen = 0;
    int  disks_placed  = 0;
    int  occupied_reads = 0;
    int  clears_seen   = 0;
    int  reg_writes    = 0;
    int  cycles_since_transfer = 0;

    disk_placement_cell_grid uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 50)
            $display("MISMATCH at %0t ns (got/expected):%s", $time, what);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len(bit allow_zero);
        int r;
        r = $urandom_range(0, 99);
        if (no_idling || r < 55)
            return allow_zero ? 0 : 1;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic item_t make_item(cmd_t op, int x, int y, int slot);
        item_t it;
        it.cmd        = op;
        it.pos_x      = x[POS_W-1:0];
        it.pos_y      = y[POS_W-1:0];
        it.slot_index = slot[ID_W-1:0];
        return it;
    endfunction

    // Leave valid high across back-to-back transactions.
    task automatic send_item(input item_t it);
        int gap;
        gap = idle_len(1'b1);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        do @(posedge clk); while (board.outcomes_due.size() != 0);
    endtask

    task automatic reg_write(input logic idx, input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] word;
        word = $urandom;
        word[CFG_W-1:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, value);
        reg_writes++;
    endtask

    // Check outcomes before noting a new command taken at the same edge.
    always @(posedge clk)
    begin
        string msg;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                msg = board.match_outcome(result);
                if (msg != "")
                    report_mismatch(msg);
                if (result.accepted === 1'b1)
                    disks_placed++;
                if (result.slot_occupied === 1'b1)
                    occupied_reads++;
            end
            if (item_valid && !item_stall)
            begin
                board.take_command(item);
                commands_seen++;
                if (cmd_t'(item.cmd) == CMD_CLEAR)
                    clears_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            cycles_since_transfer <= 0;
        else if (cycles_since_transfer >= WATCHDOG_CYCLES)
        begin
            $display("Timeout: no transaction for %0d cycles", cycles_since_transfer);
            $display("disk_placement_cell_grid verification failed");
            $finish;
        end
        else
            cycles_since_transfer <= cycles_since_transfer + 1;
    end

    // Result side: random stall runs, plus one long hold on request.
    initial
    begin : receiver
        result_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                if (!no_idling && $urandom_range(0, 2) == 0)
                begin
                    result_stall <= 1'b1;
                    repeat (idle_len(1'b0)) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int width_plan [PHASES];
        int height_plan[PHASES];
        int ph, n, w, h, pick, rx, ry, rs;
        cmd_t op;

        board = new();
        board.wipe();
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        width_plan  = '{64, 3, 10, 127, 65, 0};
        height_plan = '{64, 3, 7, 0, 2, 0};
        width_plan[5]  = $urandom_range(3, 64);
        height_plan[5] = $urandom_range(3, 64);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset box 64x64: wrap across the corner, exact unit distance, field extremes.
        send_item(make_item(CMD_READ, 0, 0, 0));
        send_item(make_item(CMD_PLACE, 0, 0, 'h3FFF));
        send_item(make_item(CMD_PLACE, 'h3FFFFF, 'h3FFFFF, 0));
        send_item(make_item(CMD_PLACE, 32768, 0, 0));
        send_item(make_item(CMD_PLACE, 65536, 0, 0));
        send_item(make_item(CMD_PLACE, 340787, 13107, 0));
        send_item(make_item(CMD_PLACE, 392560, 64880, 0));
        send_item(make_item(CMD_NOP, 'h3FFFFF, 'h3FFFFF, 'h3FFF));
        send_item(make_item(CMD_READ, 'h3FFFFF, 'h3FFFFF, 0));
        send_item(make_item(CMD_READ, 0, 0, 'h3FFF));

        // Shrink without a clear: out-of-range widths saturate, old slots land in new cells.
        wait_idle();
        reg_write(REG_GRID_WIDTH, 7'd0);
        reg_write(REG_GRID_HEIGHT, 7'd3);
        send_item(make_item(CMD_PLACE, 196608, 0, 0));
        send_item(make_item(CMD_PLACE, 65536, 196608, 0));
        send_item(make_item(CMD_PLACE, 134349, 68813, 0));
        send_item(make_item(CMD_PLACE, 193331, 127795, 0));
        send_item(make_item(CMD_READ, 0, 0, 20));
        send_item(make_item(CMD_READ, 0, 0, 23));

        // The same four slots now form a full cell with no disk nearby.
        wait_idle();
        reg_write(REG_GRID_WIDTH, 7'd5);
        reg_write(REG_GRID_HEIGHT, 7'd127);
        send_item(make_item(CMD_PLACE, 32768, 98304, 0));
        send_item(make_item(CMD_READ, 0, 0, 20));
        send_item(make_item(CMD_CLEAR, 'h3FFFFF, 'h3FFFFF, 'h3FFF));
        send_item(make_item(CMD_READ, 0, 0, 0));
        send_item(make_item(CMD_PLACE, 0, 0, 0));

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            reg_write(REG_GRID_WIDTH, width_plan[ph][CFG_W-1:0]);
            reg_write(REG_GRID_HEIGHT, height_plan[ph][CFG_W-1:0]);
            w = board.side(board.width_reg);
            h = board.side(board.height_reg);
            no_idling = (ph == 2);
            if (ph % 2 == 0)
                send_item(make_item(CMD_CLEAR, $urandom, $urandom, $urandom));
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (ph == 1 && n == 30)
                    hold_req = 1'b1;
                if (ph == 3 && n == 60)
                    wait_idle();
                pick = $urandom_range(0, 99);
                rx = $urandom;
                ry = $urandom;
                rs = $urandom;
                op = CMD_PLACE;
                if (pick < 58)
                begin
                    rx = $urandom_range(0, (w << FRAC) - 1);
                    ry = $urandom_range(0, (h << FRAC) - 1);
                end
                else if (pick < 70)
                begin
                    // hug the box edges so neighbor lookups wrap
                    rx = ($urandom_range(0, 1) ? ((w - 1) << FRAC) : 0)
                         + $urandom_range(0, int'(ONE_FIX) - 1);
                    ry = ($urandom_range(0, 1) ? ((h - 1) << FRAC) : 0)
                         + $urandom_range(0, int'(ONE_FIX) - 1);
                end
                else if (pick < 88)
                begin
                    op = CMD_READ;
                    if (pick < 81 && board.placed_at.size() > 0)
                        rs = board.placed_at[$urandom_range(0, board.placed_at.size() - 1)];
                    else if (pick < 86)
                        rs = $urandom_range(0, w * h * SLOTS - 1);
                end
                else if (pick < 99)
                    op = (pick < 94) ? CMD_PLACE : CMD_NOP;
                else
                    op = CMD_CLEAR;
                send_item(make_item(op, rx, ry, rs));
            end
        end

        no_idling = 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d commands: %0d disks placed, %0d reads of occupied slots, %0d clears.",
                 commands_seen, disks_placed, occupied_reads, clears_seen);
        $display("Box size changed by %0d register writes, out-of-range and without clears.",
                 reg_writes);
        if (errors == 0)
            $display("disk_placement_cell_grid verification clean");
        else
            $display("disk_placement_cell_grid verification failed");
        $finish;
    end

endmodule
